// ===== rtl/biq_pkg.sv =====
// biq_pkg: shared types and constants for the stereo biquad filter
// holds the payload structs, the coefficient set and the register map
// no dependencies; used by every file in rtl/
package biq_pkg;

   // bus widths fixed by the interface
   localparam int unsigned SAMPLE_BUS_W = 32;
   localparam int unsigned COEF_W       = 32;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam int unsigned CSR_ADDR_W   = 5;

   // register map, one 32-bit word per coefficient
   typedef enum logic [2:0] {
      REG_B0 = 3'd0,
      REG_B1 = 3'd1,
      REG_B2 = 3'd2,
      REG_A1 = 3'd3,
      REG_A2 = 3'd4
   } biq_reg_type;

   // coefficient reset values, signed with the fraction point at bit 30
   localparam logic signed [COEF_W-1:0] COEF_B0_RST = 32'sd1073740750;
   localparam logic signed [COEF_W-1:0] COEF_B1_RST = -32'sd1306146800;
   localparam logic signed [COEF_W-1:0] COEF_B2_RST = 32'sd572621146;
   localparam logic signed [COEF_W-1:0] COEF_A1_RST = 32'sd1306146800;
   localparam logic signed [COEF_W-1:0] COEF_A2_RST = -32'sd572621146;

   // one shared coefficient set
   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } biq_coef_type;

   // input frame
   typedef struct packed {
      logic signed [SAMPLE_BUS_W-1:0] left_in;
      logic signed [SAMPLE_BUS_W-1:0] right_in;
   } biq_req_type;

   // filtered frame
   typedef struct packed {
      logic signed [SAMPLE_BUS_W-1:0] left_out;
      logic signed [SAMPLE_BUS_W-1:0] right_out;
   } biq_rsp_type;

   // pipeline control shared by both lanes
   typedef struct packed {
      logic adv;    // every stage moves forward
      logic load;   // an input transfer enters stage one
      logic fire;   // the feedback stage produces a result
      logic clear;  // a coefficient write zeroes the histories
   } biq_ctl_type;

endpackage

// ===== rtl/biq_regs.sv =====
// biq_regs: apb-style coefficient register file
// depends on biq_pkg for the register map, reset values and coefficient struct
module biq_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [biq_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [biq_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [biq_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output biq_pkg::biq_coef_type             coef,
   output logic                              clear
);

   biq_pkg::biq_coef_type coef_ff;
   biq_pkg::biq_coef_type coef_in;
   biq_pkg::biq_reg_type  reg_idx;
   logic                  wr_en;
   logic                  hit;

   assign csr_pready = 1'b1;
   assign reg_idx    = biq_pkg::biq_reg_type'(csr_paddr[biq_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // decode and next coefficient values
   always_comb begin
      coef_in = coef_ff;
      hit     = 1'b1;
      case (reg_idx)
         biq_pkg::REG_B0: coef_in.b0 = csr_pwdata;
         biq_pkg::REG_B1: coef_in.b1 = csr_pwdata;
         biq_pkg::REG_B2: coef_in.b2 = csr_pwdata;
         biq_pkg::REG_A1: coef_in.a1 = csr_pwdata;
         biq_pkg::REG_A2: coef_in.a2 = csr_pwdata;
         default:         hit        = 1'b0;
      endcase
   end

   // read mux
   always_comb begin
      case (reg_idx)
         biq_pkg::REG_B0: csr_prdata = coef_ff.b0;
         biq_pkg::REG_B1: csr_prdata = coef_ff.b1;
         biq_pkg::REG_B2: csr_prdata = coef_ff.b2;
         biq_pkg::REG_A1: csr_prdata = coef_ff.a1;
         biq_pkg::REG_A2: csr_prdata = coef_ff.a2;
         default:         csr_prdata = '0;
      endcase
   end

   // coefficient storage
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= biq_pkg::COEF_B0_RST;
         coef_ff.b1 <= biq_pkg::COEF_B1_RST;
         coef_ff.b2 <= biq_pkg::COEF_B2_RST;
         coef_ff.a1 <= biq_pkg::COEF_A1_RST;
         coef_ff.a2 <= biq_pkg::COEF_A2_RST;
      end else if (wr_en && hit) begin
         coef_ff <= coef_in;
      end
   end

   assign coef  = coef_ff;
   assign clear = wr_en && hit;

endmodule

// ===== rtl/biq_lane.sv =====
// biq_lane: one channel of the direct form i biquad section
// three pipelined feedforward stages, then the combinational feedback stage
// depends on biq_pkg for the control and coefficient structs
module biq_lane #(
   parameter int unsigned SAMPLE_WIDTH   = 32,
   parameter int unsigned COEF_FRAC_BITS = 30
) (
   input  logic                              clock,
   input  logic                              reset,
   input  biq_pkg::biq_ctl_type              ctl,
   input  biq_pkg::biq_coef_type             coef,
   input  logic signed [SAMPLE_WIDTH-1:0]    x,
   output logic signed [SAMPLE_WIDTH-1:0]    y
);

   localparam int unsigned PROD_W = biq_pkg::COEF_W + SAMPLE_WIDTH;
   localparam int unsigned ACC_W  = PROD_W + 3;
   localparam int unsigned QUO_W  = ACC_W - COEF_FRAC_BITS;

   // input and output histories
   logic signed [SAMPLE_WIDTH-1:0] xh1_ff, xh1_in, xh2_ff, xh2_in;
   logic signed [SAMPLE_WIDTH-1:0] yh1_ff, yh1_in, yh2_ff, yh2_in;
   logic signed [PROD_W-1:0]       pa2_ff, pa2_in;

   // pipeline payload
   logic signed [SAMPLE_WIDTH-1:0] s1_x_ff, s1_x1_ff, s1_x2_ff;
   logic signed [PROD_W-1:0]       s2_p0_ff, s2_p1_ff, s2_p2_ff;
   logic signed [PROD_W-1:0]       s2_p0_in, s2_p1_in, s2_p2_in;
   logic signed [ACC_W-1:0]        s3_f_ff, s3_f_in;

   // feedback stage
   logic signed [PROD_W-1:0]       pa1;
   logic signed [ACC_W-1:0]        acc;
   logic signed [ACC_W-1:0]        quo_full;
   logic signed [QUO_W-1:0]        quo;
   logic                           round_up;
   logic                           ovf;

   // input history shifts on each input transfer and clears on a coefficient write
   always_comb begin
      xh1_in = xh1_ff;
      xh2_in = xh2_ff;
      if (ctl.clear) begin
         xh1_in = '0;
         xh2_in = '0;
      end else if (ctl.load) begin
         xh1_in = x;
         xh2_in = xh1_ff;
      end
   end

   // stage one: frame and its delayed inputs
   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         s1_x_ff  <= x;
         s1_x1_ff <= xh1_ff;
         s1_x2_ff <= xh2_ff;
      end
   end

   // stage two: feedforward products
   assign s2_p0_in = coef.b0 * s1_x_ff;
   assign s2_p1_in = coef.b1 * s1_x1_ff;
   assign s2_p2_in = coef.b2 * s1_x2_ff;

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         s2_p0_ff <= s2_p0_in;
         s2_p1_ff <= s2_p1_in;
         s2_p2_ff <= s2_p2_in;
      end
   end

   // stage three: feedforward sum
   assign s3_f_in = ACC_W'(s2_p0_ff) + ACC_W'(s2_p1_ff) + ACC_W'(s2_p2_ff);

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         s3_f_ff <= s3_f_in;
      end
   end

   // feedback: add both output terms, truncate toward zero, saturate
   assign pa1      = coef.a1 * yh1_ff;
   assign acc      = s3_f_ff + ACC_W'(pa2_ff) + ACC_W'(pa1);
   assign round_up = acc[ACC_W-1] && (|acc[COEF_FRAC_BITS-1:0]);
   assign quo_full = (acc >>> COEF_FRAC_BITS) + ACC_W'(round_up);
   assign quo      = quo_full[QUO_W-1:0];
   assign ovf      = (quo[QUO_W-1:SAMPLE_WIDTH-1] != {(QUO_W-SAMPLE_WIDTH+1){1'b0}})
                  && (quo[QUO_W-1:SAMPLE_WIDTH-1] != {(QUO_W-SAMPLE_WIDTH+1){1'b1}});

   always_comb begin
      if (!ovf) begin
         y = quo[SAMPLE_WIDTH-1:0];
      end else if (quo[QUO_W-1]) begin
         y = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         y = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
   end

   // output history; the a2 product is computed from the next y2 and registered with it
   always_comb begin
      yh1_in = yh1_ff;
      yh2_in = yh2_ff;
      if (ctl.clear) begin
         yh1_in = '0;
         yh2_in = '0;
      end else if (ctl.fire) begin
         yh1_in = y;
         yh2_in = yh1_ff;
      end
   end

   assign pa2_in = coef.a2 * yh2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         xh1_ff <= '0;
         xh2_ff <= '0;
         yh1_ff <= '0;
         yh2_ff <= '0;
         pa2_ff <= '0;
      end else begin
         xh1_ff <= xh1_in;
         xh2_ff <= xh2_in;
         yh1_ff <= yh1_in;
         yh2_ff <= yh2_in;
         pa2_ff <= pa2_in;
      end
   end

endmodule

// ===== rtl/biq_merge.sv =====
// biq_merge: joins both lane results into one output frame register
// sign-extends each channel to the bus width; depends on biq_pkg
module biq_merge #(
   parameter int unsigned SAMPLE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0]    y_left,
   input  logic signed [SAMPLE_WIDTH-1:0]    y_right,
   output logic                              adv,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output biq_pkg::biq_rsp_type              rsp_data
);

   logic                  rsp_valid_ff, rsp_valid_in;
   biq_pkg::biq_rsp_type  rsp_data_ff, rsp_data_in;

   // the register frees up when empty or when its frame is taken
   assign adv = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in          = adv ? in_valid : rsp_valid_ff;
      rsp_data_in.left_out  = biq_pkg::SAMPLE_BUS_W'(y_left);
      rsp_data_in.right_out = biq_pkg::SAMPLE_BUS_W'(y_right);
   end

   // output frame register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/stereo_biquad_iir_filter.sv =====
// stereo_biquad_iir_filter: two-lane direct form i biquad, shared coefficients
// path: an input transfer passes stage one, the products and the feedforward sum,
// then the feedback stage into the output register
// throughput: one stereo frame per cycle unless the output stalls; the feedback
// stage (one multiply, add, truncate and saturate) is combinational
// reset: synchronous; coefficients return to defaults, histories and pipe clear
module stereo_biquad_iir_filter #(
   parameter int unsigned SAMPLE_WIDTH   = 32,
   parameter int unsigned COEF_FRAC_BITS = 30
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  biq_pkg::biq_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output biq_pkg::biq_rsp_type              rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [biq_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [biq_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [biq_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   biq_pkg::biq_coef_type           coef;
   biq_pkg::biq_ctl_type            ctl;
   logic                            clear;
   logic                            adv;
   logic                            accept;
   logic                            s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0]  x_left, x_right;
   logic signed [SAMPLE_WIDTH-1:0]  y_left, y_right;

   // configuration registers
   biq_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef),
      .clear       (clear)
   );

   // pipeline control: all stages advance together
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   always_comb begin
      ctl.adv   = adv;
      ctl.load  = accept;
      ctl.fire  = adv && s3_valid_ff;
      ctl.clear = clear;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // low sample bits of each channel feed the lanes
   assign x_left  = req_data.left_in[SAMPLE_WIDTH-1:0];
   assign x_right = req_data.right_in[SAMPLE_WIDTH-1:0];

   biq_lane #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_lane_left (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .coef  (coef),
      .x     (x_left),
      .y     (y_left)
   );

   biq_lane #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_lane_right (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .coef  (coef),
      .x     (x_right),
      .y     (y_right)
   );

   // combine lane results into the output frame
   biq_merge #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .y_left    (y_left),
      .y_right   (y_right),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // an input transfer always lands in stage one
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("input transfer did not enter stage one");

   // a held, stalled result blocks new input
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while output register is blocked");

   // a finished frame reaches the output register
   a_fire_delivers: assert property (@(posedge clock) disable iff (reset)
      ctl.fire |=> rsp_valid)
      else $error("feedback result lost");

   // a new result only appears after the feedback stage held a frame
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s3_valid_ff))
      else $error("result appeared without a frame in the feedback stage");
`endif

endmodule

// ===== tb/stereo_biquad_iir_filter_tb.sv =====
// stereo_biquad_iir_filter_tb: self-checking bench for the stereo biquad filter
// drives frames and apb coefficient writes, predicts every filtered frame in sv
// depends on rtl/biq_pkg.sv and rtl/stereo_biquad_iir_filter.sv
`timescale 1ns / 1ps

module stereo_biquad_iir_filter_tb;

   localparam int unsigned FRAC_BITS   = 30;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_WAIT  = 12;
   localparam int unsigned IDLE_PCT    = 14;
   localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] x1;
      logic signed [31:0] x2;
      logic signed [31:0] y1;
      logic signed [31:0] y2;
   } lane_hist_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   biq_pkg::biq_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   biq_pkg::biq_rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [biq_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [biq_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [biq_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // predictor state: active coefficients and both channel histories
   logic signed [31:0] coef_now [5];
   lane_hist_type left_hist = '0;
   lane_hist_type right_hist = '0;

   biq_pkg::biq_req_type frames_to_send [$];
   biq_pkg::biq_rsp_type filtered_due [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit calm = 1'b0;

   stereo_biquad_iir_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // exact product of a coefficient and a sample
   function automatic logic signed [69:0] wide_mul(logic signed [31:0] c,
                                                   logic signed [31:0] v);
      logic signed [69:0] cw;
      logic signed [69:0] vw;
      cw = c;
      vw = v;
      return cw * vw;
   endfunction

   // one channel: exact sum, truncate toward zero, saturate to 32 bits
   function automatic logic signed [31:0] lane_out(lane_hist_type h,
                                                   logic signed [31:0] x);
      logic signed [69:0] acc;
      logic signed [69:0] q;
      acc = wide_mul(coef_now[biq_pkg::REG_B0], x)
          + wide_mul(coef_now[biq_pkg::REG_B1], h.x1)
          + wide_mul(coef_now[biq_pkg::REG_B2], h.x2)
          + wide_mul(coef_now[biq_pkg::REG_A1], h.y1)
          + wide_mul(coef_now[biq_pkg::REG_A2], h.y2);
      if (acc < 0) begin
         q = -((-acc) >>> FRAC_BITS);
      end else begin
         q = acc >>> FRAC_BITS;
      end
      if (q > 70'sd2147483647) begin
         q = 70'sd2147483647;
      end else if (q < -(70'sd2147483648)) begin
         q = -(70'sd2147483648);
      end
      return q[31:0];
   endfunction

   // filters one accepted frame and advances both histories
   function automatic biq_pkg::biq_rsp_type filter_frame(biq_pkg::biq_req_type f);
      biq_pkg::biq_rsp_type r;
      r.left_out  = lane_out(left_hist, f.left_in);
      r.right_out = lane_out(right_hist, f.right_in);
      left_hist  = '{x1: f.left_in, x2: left_hist.x1, y1: r.left_out, y2: left_hist.y1};
      right_hist = '{x1: f.right_in, x2: right_hist.x1, y1: r.right_out,
                     y2: right_hist.y1};
      return r;
   endfunction

   // sender: holds the frame while stalled, idles at random otherwise unless calm
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            filtered_due.push_back(filter_frame(req_data));
         end
         if (frames_to_send.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_data  <= frames_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall, compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (filtered_due.size() == 0) begin
               $display("%0t: unexpected result left=%0d right=%0d", $time,
                        rsp_data.left_out, rsp_data.right_out);
               error_count++;
            end else begin
               biq_pkg::biq_rsp_type want;
               want = filtered_due.pop_front();
               if (rsp_data.left_out !== want.left_out) begin
                  $display("%0t: left_out expected %0d actual %0d", $time,
                           want.left_out, rsp_data.left_out);
                  error_count++;
               end
               if (rsp_data.right_out !== want.right_out) begin
                  $display("%0t: right_out expected %0d actual %0d", $time,
                           want.right_out, rsp_data.right_out);
                  error_count++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[stereo_biquad_iir_filter] ERROR");
         $finish;
      end
   end

   task automatic queue_frame(logic signed [31:0] l, logic signed [31:0] r);
      biq_pkg::biq_req_type f;
      f.left_in  = l;
      f.right_in = r;
      frames_to_send.push_back(f);
   endtask

   // wait until every frame is sent and every result has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (frames_to_send.size() != 0 || req_valid || filtered_due.size() != 0);
   endtask

   // apb write; a coefficient write clears both histories in the predictor
   task automatic csr_write(logic [biq_pkg::CSR_ADDR_W-1:0] addr, logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr[1:0] == 2'b00 && addr[4:2] <= biq_pkg::REG_A2) begin
         coef_now[addr[4:2]] = val;
         left_hist  = '0;
         right_hist = '0;
      end
   endtask

   // apb read of a coefficient, checked against the predictor
   task automatic csr_check(biq_pkg::biq_reg_type r);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {r, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      if (csr_prdata !== coef_now[r]) begin
         $display("%0t: coefficient %s expected %0d actual %0d", $time, r.name(),
                  coef_now[r], $signed(csr_prdata));
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic load_coefs(logic signed [31:0] vals [5]);
      for (int i = 0; i < 5; i++) begin
         csr_write({biq_pkg::biq_reg_type'(i), 2'b00}, vals[i]);
         csr_check(biq_pkg::biq_reg_type'(i));
      end
   endtask

   function automatic logic signed [31:0] rand_coef(int i);
      case ($urandom_range(5))
         0: return S_MAX;
         1: return S_MIN;
         2: return (i == 0) ? biq_pkg::COEF_B0_RST : (i == 1) ? biq_pkg::COEF_B1_RST :
                   (i == 2) ? biq_pkg::COEF_B2_RST : (i == 3) ? biq_pkg::COEF_A1_RST :
                   biq_pkg::COEF_A2_RST;
         3: return $signed($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
         default: return $urandom;
      endcase
   endfunction

   // 24-bit left-justified audio in four of ten draws, else full-range, zero and extreme values
   function automatic logic signed [31:0] rand_sample();
      case ($urandom_range(9))
         0: return S_MAX;
         1: return S_MIN;
         2: return 32'sd0;
         3, 4, 5, 6: return {24'($urandom_range(32'h00FF_FFFF)), 8'h00};
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic signed [31:0] vals [5];
      coef_now = '{biq_pkg::COEF_B0_RST, biq_pkg::COEF_B1_RST, biq_pkg::COEF_B2_RST,
                   biq_pkg::COEF_A1_RST, biq_pkg::COEF_A2_RST};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed frames on the reset coefficients
      @(negedge clock);
      queue_frame(0, 0);
      queue_frame(S_MAX, S_MIN);
      queue_frame(S_MIN, S_MAX);
      queue_frame(1, -1);
      queue_frame(-1, 1);
      queue_frame(S_MAX, S_MAX);
      queue_frame(S_MIN, S_MIN);
      queue_frame(32'sh7FFF_FF00, 32'sh8000_0100);
      queue_frame(32'sh5555_5500, 32'shAAAA_AA00);
      wait_idle();
      for (int i = 0; i < 5; i++) csr_check(biq_pkg::biq_reg_type'(i));

      // largest coefficients drive both ends of saturation
      vals = '{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX};
      load_coefs(vals);
      @(negedge clock);
      queue_frame(S_MAX, S_MIN);
      queue_frame(S_MAX, S_MIN);
      queue_frame(S_MIN, S_MAX);
      wait_idle();
      vals = '{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN};
      load_coefs(vals);
      @(negedge clock);
      queue_frame(S_MAX, S_MAX);
      queue_frame(S_MIN, 32'sh0000_0100);
      queue_frame(32'sh1234_5600, S_MIN);
      wait_idle();

      // rewriting an unchanged value still clears the histories
      csr_write({biq_pkg::REG_A2, 2'b00}, S_MIN);
      @(negedge clock);
      queue_frame(S_MAX, -1);
      queue_frame(1, S_MIN);
      wait_idle();

      // writes beyond the register map are ignored, histories kept
      csr_write(5'd20, 32'h1234_5678);
      csr_write(5'd28, 32'hFFFF_FFFF);
      @(negedge clock);
      queue_frame(32'sh0040_0000, 32'shFFC0_0000);
      queue_frame(S_MIN, S_MAX);
      wait_idle();
      for (int i = 0; i < 5; i++) csr_check(biq_pkg::biq_reg_type'(i));

      // random phases, each on its own coefficient set; the first runs without idling
      for (int p = 0; p < 5; p++) begin
         calm = (p == 0);
         if (p == 1) begin
            vals = '{biq_pkg::COEF_B0_RST, biq_pkg::COEF_B1_RST, biq_pkg::COEF_B2_RST,
                     biq_pkg::COEF_A1_RST, biq_pkg::COEF_A2_RST};
         end else begin
            for (int i = 0; i < 5; i++) vals[i] = rand_coef(i);
         end
         load_coefs(vals);
         @(negedge clock);
         for (int n = 0; n < 60; n++) queue_frame(rand_sample(), rand_sample());
         // sender holds off until the pipe has fully drained
         wait_idle();
         for (int n = 0; n < 60; n++) queue_frame(rand_sample(), rand_sample());
         wait_idle();
      end
      calm = 1'b0;

      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("[stereo_biquad_iir_filter] OK");
      end else begin
         $display("[stereo_biquad_iir_filter] ERROR");
      end
      $finish;
   end

endmodule
